// ----- design/fenwick_range_count_top_defines.svh -----
// Assertion macros for the Fenwick range-count block.
// Included by the controller and datapath; expects clk_i and rst_ni in scope.
`ifndef FENWICK_RANGE_COUNT_TOP_DEFINES_SVH
`define FENWICK_RANGE_COUNT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FRC_ASSERT(lbl, prop, msg)
`define FRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/frc_pkg.sv -----
// Shared types and constants of the Fenwick range-count block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package frc_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned SUM_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic walk_up;
    logic walk_down;
    logic sub;
    logic load_lo;
    logic load_res;
  } dp_cmd_t;

  typedef struct packed {
    logic up_done;
    logic down_done;
    logic clr_last;
  } dp_status_t;

endpackage

// ----- design/frc_req_if.sv -----
// Request channel of the Fenwick range-count block: valid/ready plus payload.
// Depends on frc_pkg for field widths.
interface frc_req_if;
  logic                               valid;
  logic                               ready;
  logic [frc_pkg::OP_W-1:0]           opcode;
  logic [frc_pkg::POS_W-1:0]          low_pos;
  logic [frc_pkg::POS_W-1:0]          high_pos;
  logic signed [frc_pkg::DELTA_W-1:0] delta;

  modport source (output valid, opcode, low_pos, high_pos, delta, input ready);
  modport sink (input valid, opcode, low_pos, high_pos, delta, output ready);
endinterface

// ----- design/frc_res_if.sv -----
// Result channel of the Fenwick range-count block: valid/ready plus range sum.
// Depends on frc_pkg for the field width.
interface frc_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [frc_pkg::SUM_W-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink (input valid, range_sum, output ready);
endinterface

// ----- design/frc_datapath.sv -----
// Datapath: tree node memory, node walker, accumulator, clear sweep, result register.
// Depends on frc_pkg and the assertion macros header.
`include "fenwick_range_count_top_defines.svh"
module frc_datapath #(
  parameter int unsigned POSITIONS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  frc_pkg::dp_cmd_t                   cmd_i,
  input  logic [frc_pkg::OP_W-1:0]           req_opcode_i,
  input  logic [frc_pkg::POS_W-1:0]          req_low_pos_i,
  input  logic [frc_pkg::POS_W-1:0]          req_high_pos_i,
  input  logic signed [frc_pkg::DELTA_W-1:0] req_delta_i,
  output frc_pkg::dp_status_t                status_o,
  output logic signed [frc_pkg::SUM_W-1:0]   range_sum_o
);
  import frc_pkg::*;

  localparam int unsigned AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned NW = ($clog2(POSITIONS) + 2 > POS_W + 2) ?
                               $clog2(POSITIONS) + 2 : POS_W + 2;
  localparam logic [NW-1:0] POS_LIM = NW'(POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(POSITIONS - 1);

  logic [SUM_W-1:0] mem_q [POSITIONS];

  logic [NW-1:0]    node_q, node_d;
  logic [NW-1:0]    node_lo_q;
  logic [NW-1:0]    lo_ext, hi_ext, hi_node, lo_node, add_node, low_bit;
  logic             empty;
  logic [AW-1:0]    clr_cnt_q;
  logic [AW-1:0]    raddr, wr_addr_q, waddr;
  logic             re, we;
  logic [SUM_W-1:0] wdata, rdata_q, amount_q, acc_q, range_sum_q;
  logic             rd_pend_q, rd_sub_q, rd_add_q;

  assign lo_ext   = NW'(req_low_pos_i);
  assign hi_ext   = NW'(req_high_pos_i);
  assign empty    = req_low_pos_i > req_high_pos_i;
  assign hi_node  = empty ? '0 : ((hi_ext >= POS_LIM) ? POS_LIM : hi_ext + NW'(1));
  assign lo_node  = empty ? '0 : ((lo_ext > POS_LIM) ? POS_LIM : lo_ext);
  assign add_node = lo_ext + NW'(1);
  assign low_bit  = node_q & (~node_q + NW'(1));

  assign re    = cmd_i.walk_up | cmd_i.walk_down;
  assign raddr = AW'(node_q - NW'(1));
  assign we    = cmd_i.clr_step | (rd_pend_q & rd_add_q);
  assign waddr = cmd_i.clr_step ? clr_cnt_q : wr_addr_q;
  assign wdata = cmd_i.clr_step ? '0 : rdata_q + amount_q;

  always_comb begin
    node_d = node_q;
    if (cmd_i.load) begin
      node_d = (op_e'(req_opcode_i) == OP_ADD) ? add_node : hi_node;
    end else if (cmd_i.load_lo) begin
      node_d = node_lo_q;
    end else if (cmd_i.walk_up) begin
      node_d = node_q + low_bit;
    end else if (cmd_i.walk_down) begin
      node_d = node_q - low_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q    <= '0;
      clr_cnt_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      node_q    <= node_d;
      rd_pend_q <= re;
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sub_q  <= cmd_i.sub;
    rd_add_q  <= cmd_i.walk_up;
    wr_addr_q <= raddr;
    if (cmd_i.load) begin
      node_lo_q <= lo_node;
      amount_q  <= {{(SUM_W - DELTA_W){req_delta_i[DELTA_W-1]}}, req_delta_i};
      acc_q     <= '0;
    end else if (rd_pend_q && !rd_add_q) begin
      acc_q <= rd_sub_q ? acc_q - rdata_q : acc_q + rdata_q;
    end
    if (cmd_i.load_res) begin
      range_sum_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign status_o.up_done   = node_q > POS_LIM;
  assign status_o.down_done = node_q == '0;
  assign status_o.clr_last  = clr_cnt_q == LAST_ADDR;
  assign range_sum_o        = signed'(range_sum_q);

  `FRC_ASSERT(a_clr_no_add_wr, cmd_i.clr_step |-> !(rd_pend_q && rd_add_q), "clear vs add write")
endmodule

// ----- design/frc_ctrl.sv -----
// Controller: sequences clear sweep, add walk and two-sided query walk; owns result valid.
// Depends on frc_pkg and the assertion macros header.
`include "fenwick_range_count_top_defines.svh"
module frc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic [frc_pkg::OP_W-1:0] req_opcode_i,
  output logic                     req_ready_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  input  frc_pkg::dp_status_t      status_i,
  output frc_pkg::dp_cmd_t         cmd_o
);
  import frc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_QHI,
    S_QLO,
    S_DRAIN,
    S_RES
  } state_e;

  state_e  state_q, state_d;
  logic    query_q, query_d;
  logic    out_valid_q, out_valid_d;
  logic    accept;
  dp_cmd_t cmd;

  assign req_ready_o = state_q == S_IDLE;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    query_d     = query_q;
    out_valid_d = out_valid_q;
    if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (op_e'(req_opcode_i))
            OP_ADD: begin
              query_d = 1'b0;
              state_d = S_ADD;
            end
            OP_QUERY: begin
              query_d = 1'b1;
              state_d = S_QHI;
            end
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_d       = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (status_i.up_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd.walk_up = 1'b1;
        end
      end
      S_QHI: begin
        if (status_i.down_done) begin
          cmd.load_lo = 1'b1;
          state_d     = S_QLO;
        end else begin
          cmd.walk_down = 1'b1;
        end
      end
      S_QLO: begin
        if (status_i.down_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd.walk_down = 1'b1;
          cmd.sub       = 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = query_q ? S_RES : S_IDLE;
      end
      S_RES: begin
        if (!out_valid_q || res_ready_i) begin
          cmd.load_res = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      query_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      query_q     <= query_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `FRC_ASSERT(a_walk_down_live, cmd.walk_down |-> !status_i.down_done, "walk past tree root")
  `FRC_ASSERT(a_walk_up_live, cmd.walk_up |-> !status_i.up_done, "walk past last node")
  `FRC_ASSERT(a_res_slot_free, cmd.load_res |-> (!out_valid_q || res_ready_i), "result overwritten")
  `FRC_ASSERT(a_res_raises, cmd.load_res |=> out_valid_q, "loaded result not presented")
  `FRC_ASSERT_ALWAYS(a_one_mem_op, $onehot0({cmd.walk_up, cmd.walk_down, cmd.clr_step}), "memory ops overlap")
endmodule

// ----- design/fenwick_range_count_top.sv -----
// Fenwick range count: add a delta at a position, query an inclusive range sum, clear all.
// Query steps: a query walks the high-side nodes, then the low-side nodes, then drains and
// loads the result register; one node memory read per cycle during the walks.
// Requests: one at a time; the next is taken once an add's walk and drain are done, in the
// cycle a query's result becomes valid, and once a clear's sweep has finished.
// Reset: a clearing pass zeroes the node memory; no request is taken then.
module fenwick_range_count_top #(
  parameter int unsigned POSITIONS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  frc_req_if.sink   req_i,
  frc_res_if.source res_o
);
  import frc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  frc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  frc_datapath #(
    .POSITIONS (POSITIONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_opcode_i   (req_i.opcode),
    .req_low_pos_i  (req_i.low_pos),
    .req_high_pos_i (req_i.high_pos),
    .req_delta_i    (req_i.delta),
    .status_o       (status),
    .range_sum_o    (res_o.range_sum)
  );
endmodule
